[hw/rtl/ips_patch_stream_applier_assert.svh]
// Assertion macros used by the patch applier command queue.
`ifndef IPS_PATCH_STREAM_APPLIER_ASSERT_SVH
`define IPS_PATCH_STREAM_APPLIER_ASSERT_SVH

// Checks a condition in the same cycle as its trigger.
`define IPSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("ipsa: same-cycle check failed");

// Checks a condition in the cycle after its trigger.
`define IPSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("ipsa: next-cycle check failed");

`endif

[hw/rtl/ipsa_pkg.sv]
// Shared types and constants of the IPS patch stream applier.
package ipsa_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    // One command from the parser to the write stage. The address keeps a
    // carry bit so that a data run cannot wrap back to zero.
    typedef struct packed {
        kind_t       kind;
        logic [24:0] addr;
        logic [15:0] count;
        logic [7:0]  value;
    } cmd_t;

    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // Register select is bit 2 of the byte address.
    localparam logic REG_ROM_LENGTH  = 1'b0;
    localparam logic REG_BODY_LENGTH = 1'b1;

endpackage

[hw/rtl/ipsa_front.sv]
// Parser: checks the header, assembles record fields, applies the ROM limit and issues commands.
module ipsa_front #(
    parameter int ADDR_BITS = 24
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // patch_byte
    input  logic [0:0]        s_tuser,   // first_byte
    input  logic [24:0]       rom_length,
    input  logic [31:0]       body_length,
    input  logic              q_full,
    output logic              push,
    output ipsa_pkg::cmd_t    push_cmd
);

    localparam logic [24:0] ADDR_CAP = 25'd1 << ADDR_BITS;

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_ADDR   = 7'b0000010,
        PH_LEN    = 7'b0000100,
        PH_DATA   = 7'b0001000,
        PH_RUN    = 7'b0010000,
        PH_FILL   = 7'b0100000,
        PH_DONE   = 7'b1000000
    } phase_t;

    function automatic logic [7:0] magic_upper(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h50;
            3'd1:    r = 8'h41;
            3'd2:    r = 8'h54;
            3'd3:    r = 8'h43;
            default: r = 8'h48;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] magic_lower(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h70;
            3'd1:    r = 8'h61;
            3'd2:    r = 8'h74;
            3'd3:    r = 8'h63;
            default: r = 8'h68;
        endcase
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [2:0]  fidx_reg, fidx_next;
    logic        upper_ok_reg, upper_ok_next;
    logic        lower_ok_reg, lower_ok_next;
    logic [31:0] consumed_reg, consumed_next;
    logic [24:0] rec_addr_reg, rec_addr_next;
    logic [15:0] rec_len_reg, rec_len_next;

    phase_t      ph;
    logic [2:0]  fi;
    logic [2:0]  hidx;
    logic        up_ok;
    logic        lo_ok;
    logic [31:0] consumed;
    logic [15:0] len_shift;
    logic        accept;
    logic [7:0]  b;
    logic [24:0] limit;
    logic [24:0] room;
    logic        in_range;
    logic [15:0] clip_count;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign b        = s_tdata;

    always_comb begin
        // A first byte restarts the parse before the byte itself is looked at.
        ph       = s_tuser[0] ? PH_HEADER : phase_reg;
        fi       = s_tuser[0] ? 3'd0 : fidx_reg;
        up_ok    = s_tuser[0] ? 1'b1 : upper_ok_reg;
        lo_ok    = s_tuser[0] ? 1'b1 : lower_ok_reg;
        consumed = s_tuser[0] ? 32'd0 : consumed_reg;
        hidx     = (fi < 3'd5) ? fi : 3'd4;
        len_shift = (fi == 3'd0) ? {8'd0, b} : {rec_len_reg[7:0], b};

        limit      = (rom_length < ADDR_CAP) ? rom_length : ADDR_CAP;
        in_range   = rec_addr_reg < limit;
        room       = limit - rec_addr_reg;
        clip_count = ({9'd0, rec_len_reg} < room) ? rec_len_reg : room[15:0];

        phase_next    = phase_reg;
        fidx_next     = fidx_reg;
        upper_ok_next = upper_ok_reg;
        lower_ok_next = lower_ok_reg;
        consumed_next = consumed_reg;
        rec_addr_next = rec_addr_reg;
        rec_len_next  = rec_len_reg;
        push          = 1'b0;
        push_cmd      = '0;

        if (accept) begin
            phase_next    = ph;
            fidx_next     = fi;
            upper_ok_next = up_ok;
            lower_ok_next = lo_ok;
            consumed_next = consumed;
            case (ph)
                PH_HEADER: begin
                    upper_ok_next = up_ok && (b == magic_upper(hidx));
                    lower_ok_next = lo_ok && (b == magic_lower(hidx));
                    if (hidx < 3'd4) begin
                        fidx_next = hidx + 3'd1;
                    end else begin
                        fidx_next = 3'd0;
                        if (!(upper_ok_next || lower_ok_next) || body_length == 32'd0) begin
                            phase_next    = PH_DONE;
                            push          = 1'b1;
                            push_cmd.kind = ipsa_pkg::KIND_ERROR;
                        end else begin
                            phase_next    = PH_ADDR;
                            consumed_next = 32'd0;
                        end
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    if (ph == PH_ADDR && fi == 3'd0 && consumed >= body_length) begin
                        phase_next = PH_DONE;
                    end else begin
                        if (consumed != '1) begin
                            consumed_next = consumed + 32'd1;
                        end
                        case (ph)
                            PH_ADDR: begin
                                rec_addr_next = (fi == 3'd0) ? {17'd0, b}
                                                             : {1'b0, rec_addr_reg[15:0], b};
                                if (fi >= 3'd2) begin
                                    fidx_next  = 3'd0;
                                    phase_next = PH_LEN;
                                end else begin
                                    fidx_next = fi + 3'd1;
                                end
                            end
                            PH_LEN, PH_RUN: begin
                                rec_len_next = len_shift;
                                if (fi >= 3'd1) begin
                                    fidx_next = 3'd0;
                                    if (ph == PH_RUN) begin
                                        phase_next = PH_FILL;
                                    end else if (len_shift == 16'd0) begin
                                        phase_next = PH_RUN;
                                    end else begin
                                        phase_next = PH_DATA;
                                    end
                                end else begin
                                    fidx_next = fi + 3'd1;
                                end
                            end
                            PH_DATA: begin
                                // The address stops at the limit, so the rest of
                                // a run that reaches it is dropped.
                                if (in_range) begin
                                    push           = 1'b1;
                                    push_cmd.kind  = ipsa_pkg::KIND_WRITE;
                                    push_cmd.addr  = rec_addr_reg;
                                    push_cmd.count = 16'd1;
                                    push_cmd.value = b;
                                    rec_addr_next  = rec_addr_reg + 25'd1;
                                end
                                rec_len_next = rec_len_reg - 16'd1;
                                if (rec_len_reg == 16'd1) begin
                                    phase_next = PH_ADDR;
                                    fidx_next  = 3'd0;
                                end
                            end
                            PH_FILL: begin
                                push           = in_range && (clip_count != 16'd0);
                                push_cmd.kind  = ipsa_pkg::KIND_FILL;
                                push_cmd.addr  = rec_addr_reg;
                                push_cmd.count = clip_count;
                                push_cmd.value = b;
                                phase_next     = PH_ADDR;
                                fidx_next      = 3'd0;
                            end
                            default: begin
                                phase_next = PH_DONE;
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            fidx_reg     <= 3'd0;
            upper_ok_reg <= 1'b1;
            lower_ok_reg <= 1'b1;
            consumed_reg <= 32'd0;
        end else begin
            phase_reg    <= phase_next;
            fidx_reg     <= fidx_next;
            upper_ok_reg <= upper_ok_next;
            lower_ok_reg <= lower_ok_next;
            consumed_reg <= consumed_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_addr_reg <= rec_addr_next;
        rec_len_reg  <= rec_len_next;
    end

endmodule

[hw/rtl/ipsa_cmd_queue.sv]
// Short command queue between the parser and the write stage.
`include "ips_patch_stream_applier_assert.svh"

module ipsa_cmd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ipsa_pkg::cmd_t    push_cmd,
    output logic              full,
    output logic              head_valid,
    output ipsa_pkg::cmd_t    head_cmd,
    input  logic              pop
);

    localparam int PW = ipsa_pkg::Q_PTR_W;
    localparam int CW = ipsa_pkg::Q_CNT_W;

    ipsa_pkg::cmd_t entry_reg [ipsa_pkg::Q_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(ipsa_pkg::Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `IPSA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CW'(ipsa_pkg::Q_DEPTH))
    `IPSA_ASSERT_NOW(a_no_pop_empty, pop, cnt_reg != '0)
    `IPSA_ASSERT_NEXT(a_cnt_grows, push && !pop, cnt_reg == CW'($past(cnt_reg) + 1'b1))

endmodule

[hw/rtl/ipsa_back.sv]
// Output stage: takes commands from the queue and holds the result word.
module ipsa_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  ipsa_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,   // address, count, value
    output logic [1:0]        m_tuser    // kind
);

    logic           can_load;
    logic           valid_reg, valid_next;
    ipsa_pkg::cmd_t out_reg, out_next;

    always_comb begin
        can_load = !valid_reg || m_tready;
        pop      = head_valid && can_load;

        valid_next = valid_reg;
        out_next   = out_reg;
        if (can_load) begin
            valid_next = head_valid;
            if (head_valid) begin
                out_next = head_cmd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_reg.value, out_reg.count, out_reg.addr[23:0]};
    assign m_tuser  = out_reg.kind;

endmodule

[hw/rtl/ips_patch_stream_applier.sv]
// Top level of the IPS patch stream applier: register port, parser, queue, write stage.
//
//   port group  direction  word contents
//   s_*         in         tdata[7:0] patch byte, tuser[0] first byte of a file
//   m_*         out        tdata address/count/value, tuser[1:0] result kind
//   p*          in/out     rom_length at 0x0, body_length at 0x4
//
// One input word is taken per cycle while the queue has room; results are registered.
// The parser and the write stage are parted by a four-word command queue, so a
// stall on m_tready only reaches s_tready once that queue has filled.
// Reset is synchronous on aresetn and returns the parser to the header check.
// A first-byte flag restarts the parse at any time.
module ips_patch_stream_applier #(
    parameter int ADDR_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] patch_byte
    input  logic [0:0]  s_tuser,   // [0] first_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [23:0] address, [39:24] count, [47:40] value
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [24:0]    rom_len_reg, rom_len_next;
    logic [31:0]    body_len_reg, body_len_next;
    logic           cfg_write;
    logic           q_full;
    logic           push;
    ipsa_pkg::cmd_t push_cmd;
    logic           head_valid;
    ipsa_pkg::cmd_t head_cmd;
    logic           pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        rom_len_next  = rom_len_reg;
        body_len_next = body_len_reg;
        if (cfg_write) begin
            case (paddr[2])
                ipsa_pkg::REG_ROM_LENGTH:  rom_len_next  = pwdata[24:0];
                ipsa_pkg::REG_BODY_LENGTH: body_len_next = pwdata;
                default: ;
            endcase
        end
        prdata = (paddr[2] == ipsa_pkg::REG_BODY_LENGTH) ? body_len_reg : {7'd0, rom_len_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_len_reg  <= 25'd0;
            body_len_reg <= 32'd0;
        end else begin
            rom_len_reg  <= rom_len_next;
            body_len_reg <= body_len_next;
        end
    end

    ipsa_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .rom_length  (rom_len_reg),
        .body_length (body_len_reg),
        .q_full      (q_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    ipsa_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    ipsa_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

[dv/ips_patch_stream_applier_test.sv]
// Self-checking testbench for the IPS patch stream applier: patch files in, ROM write commands out.
module ips_patch_stream_applier_test;

    localparam logic [39:0] MAGIC_UPPER = "PATCH";
    localparam logic [39:0] MAGIC_LOWER = "patch";
    localparam logic [24:0] ADDR_SPACE  = 25'h1000000;
    localparam logic [2:0]  ADDR_ROM_LENGTH  = {ipsa_pkg::REG_ROM_LENGTH, 2'b00};
    localparam logic [2:0]  ADDR_BODY_LENGTH = {ipsa_pkg::REG_BODY_LENGTH, 2'b00};
    localparam int IDLE_PERCENT = 35;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 65;

    typedef enum logic [2:0] {
        PS_HEADER, PS_ADDR, PS_LEN, PS_DATA, PS_RUN, PS_FILL, PS_DONE
    } parse_state_t;

    typedef struct packed {
        ipsa_pkg::kind_t kind;
        logic [23:0]     address;
        logic [15:0]     count;
        logic [7:0]      value;
    } rom_cmd_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } patch_byte_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] patch_byte
    logic [0:0]  s_tuser;   // [0] first_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [23:0] address, [39:24] count, [47:40] value
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ips_patch_stream_applier DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Parser copy: configuration and state.
    logic [24:0]  rom_len;
    logic [31:0]  body_len;
    parse_state_t ps;
    int           field;
    logic [24:0]  rec_addr;
    logic [15:0]  rec_len;
    logic [31:0]  consumed;
    logic         upper_ok;
    logic         lower_ok;

    rom_cmd_t    rom_cmds_due[$];
    patch_byte_t patch_bytes_pending[$];
    patch_byte_t next_byte;

    int  bytes_queued;
    int  bytes_accepted;
    int  failures;
    int  n_writes;
    int  n_fills;
    int  n_errors;
    int  n_settings;
    bit  byte_taken;
    bit  no_gaps;
    bit  stall_req;
    int  hold_left;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic void restart_parse();
        ps       = PS_HEADER;
        field    = 0;
        rec_addr = '0;
        rec_len  = '0;
        consumed = '0;
        upper_ok = 1'b1;
        lower_ok = 1'b1;
    endfunction

    function automatic void queue_cmd(ipsa_pkg::kind_t k, logic [23:0] a, logic [15:0] c,
                                      logic [7:0] v);
        rom_cmd_t cmd;
        cmd.kind    = k;
        cmd.address = a;
        cmd.count   = c;
        cmd.value   = v;
        rom_cmds_due.push_back(cmd);
    endfunction

    // Advances the parser by one patch byte and queues the command it causes, if any.
    function automatic void apply_patch_byte(logic [7:0] b, logic first);
        logic [24:0] lim;
        logic [24:0] room;
        logic [24:0] run;
        int          i;
        lim = (rom_len < ADDR_SPACE) ? rom_len : ADDR_SPACE;
        if (first)
            restart_parse();
        if (ps == PS_DONE)
            return;
        if (ps == PS_HEADER) begin
            i = field;
            if (b != MAGIC_UPPER[39 - 8*i -: 8]) upper_ok = 1'b0;
            if (b != MAGIC_LOWER[39 - 8*i -: 8]) lower_ok = 1'b0;
            field = i + 1;
            if (field < 5)
                return;
            field = 0;
            if (!(upper_ok || lower_ok) || body_len == 0) begin
                ps = PS_DONE;
                queue_cmd(ipsa_pkg::KIND_ERROR, '0, '0, '0);
                return;
            end
            ps = PS_ADDR;
            consumed = '0;
            return;
        end
        // A new record may only begin inside the body.
        if (ps == PS_ADDR && field == 0 && consumed >= body_len) begin
            ps = PS_DONE;
            return;
        end
        if (consumed != 32'hFFFF_FFFF)
            consumed++;
        case (ps)
            PS_ADDR: begin
                rec_addr = (field == 0) ? {17'd0, b} : {1'b0, rec_addr[15:0], b};
                field++;
                if (field >= 3) begin
                    field = 0;
                    ps = PS_LEN;
                end
            end
            PS_LEN, PS_RUN: begin
                rec_len = (field == 0) ? {8'd0, b} : {rec_len[7:0], b};
                field++;
                if (field >= 2) begin
                    field = 0;
                    if (ps == PS_RUN)
                        ps = PS_FILL;
                    else
                        ps = (rec_len == 0) ? PS_RUN : PS_DATA;
                end
            end
            PS_DATA: begin
                // The spare address bit stops a run that passes the top from wrapping.
                if (rec_addr < lim) begin
                    queue_cmd(ipsa_pkg::KIND_WRITE, rec_addr[23:0], 16'd1, b);
                    rec_addr++;
                end
                rec_len--;
                if (rec_len == 0) begin
                    ps = PS_ADDR;
                    field = 0;
                end
            end
            PS_FILL: begin
                ps = PS_ADDR;
                field = 0;
                if (rec_addr < lim) begin
                    room = lim - rec_addr;
                    run = ({9'd0, rec_len} < room) ? {9'd0, rec_len} : room;
                    if (run != 0)
                        queue_cmd(ipsa_pkg::KIND_FILL, rec_addr[23:0], run[15:0], b);
                end
            end
            default: ps = PS_DONE;
        endcase
    endfunction

    // Input driver: a new word goes out once the previous one has been taken.
    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || byte_taken)) begin
            if (patch_bytes_pending.size() != 0 &&
                (no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                next_byte = patch_bytes_pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_byte.data;
                s_tuser  <= next_byte.first;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure, with one long hold-off on request.
    always @(negedge aclk) begin
        if (stall_req) begin
            stall_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= no_gaps || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    always @(posedge aclk) begin
        rom_cmd_t due;
        byte_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            apply_patch_byte(s_tdata, s_tuser[0]);
            bytes_accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (rom_cmds_due.size() == 0) begin
                $error("result word with none expected: kind %0d address %h count %0d value %h",
                       m_tuser, m_tdata[23:0], m_tdata[39:24], m_tdata[47:40]);
                failures++;
            end else begin
                due = rom_cmds_due.pop_front();
                case (due.kind)
                    ipsa_pkg::KIND_WRITE: n_writes++;
                    ipsa_pkg::KIND_FILL:  n_fills++;
                    default:              n_errors++;
                endcase
                if (m_tuser !== due.kind) begin
                    $error("kind: expected %0d, actual %0d", due.kind, m_tuser);
                    failures++;
                end
                if (m_tdata[23:0] !== due.address) begin
                    $error("address: expected %h, actual %h", due.address, m_tdata[23:0]);
                    failures++;
                end
                if (m_tdata[39:24] !== due.count) begin
                    $error("count: expected %0d, actual %0d", due.count, m_tdata[39:24]);
                    failures++;
                end
                if (m_tdata[47:40] !== due.value) begin
                    $error("value: expected %h, actual %h", due.value, m_tdata[47:40]);
                    failures++;
                end
            end
        end
    end

    function automatic void push_byte(logic [7:0] b, logic first);
        patch_byte_t item;
        item.data  = b;
        item.first = first;
        patch_bytes_pending.push_back(item);
        bytes_queued++;
    endfunction

    function automatic void push_header(logic [39:0] magic);
        for (int j = 0; j < 5; j++)
            push_byte(magic[39 - 8*j -: 8], j == 0);
    endfunction

    // Record addresses lie mostly inside the ROM, some near its end or the address-space top.
    function automatic logic [23:0] pick_addr(logic [24:0] rom);
        logic [24:0] a;
        case ($urandom_range(0, 9))
            0:       a = (rom < ADDR_SPACE) ? rom : 25'hFF_FFFF;
            1:       a = (rom > 8) ? rom - 25'($urandom_range(1, 8)) : 25'd0;
            2:       a = 25'($urandom);
            3:       a = 25'hFF_FFFF - 25'($urandom_range(0, 8));
            default: a = (rom == 0) ? 25'($urandom) : 25'($urandom_range(0, rom - 1));
        endcase
        return a[23:0];
    endfunction

    function automatic logic [15:0] pick_run();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 64));
        endcase
    endfunction

    // One patch file: mostly well formed, sometimes with a damaged header,
    // a truncated record, a trailing end marker or stray words.
    function automatic void send_file(logic [24:0] rom);
        logic [39:0] hdr;
        logic [23:0] a;
        logic [15:0] len;
        int          idx;
        int          n_rec;
        hdr = $urandom_range(0, 1) ? MAGIC_UPPER : MAGIC_LOWER;
        if ($urandom_range(0, 99) < 12) begin
            idx = $urandom_range(0, 39);
            hdr[idx] = ~hdr[idx];
        end
        push_header(hdr);
        n_rec = $urandom_range(1, 6);
        for (int r = 0; r < n_rec; r++) begin
            if ($urandom_range(0, 99) < 5) begin
                for (int k = $urandom_range(1, 4); k > 0; k--)
                    push_byte(8'($urandom), 1'b0);
                return;
            end
            a = pick_addr(rom);
            push_byte(a[23:16], 1'b0);
            push_byte(a[15:8], 1'b0);
            push_byte(a[7:0], 1'b0);
            if ($urandom_range(0, 99) < 70) begin
                len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(1, 40))
                                                  : 16'($urandom_range(1, 6));
                push_byte(len[15:8], 1'b0);
                push_byte(len[7:0], 1'b0);
                for (int k = 0; k < len; k++)
                    push_byte(8'($urandom), 1'b0);
            end else begin
                len = pick_run();
                push_byte(8'h00, 1'b0);
                push_byte(8'h00, 1'b0);
                push_byte(len[15:8], 1'b0);
                push_byte(len[7:0], 1'b0);
                push_byte(8'($urandom), 1'b0);
            end
        end
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                push_byte("E", 1'b0);
                push_byte("O", 1'b0);
                push_byte("F", 1'b0);
            end
            3: begin
                for (int k = $urandom_range(1, 4); k > 0; k--)
                    push_byte(8'($urandom), $urandom_range(0, 3) == 0);
            end
            default: ;
        endcase
    endfunction

    task automatic write_reg(input logic [2:0] a, input logic [31:0] d);
        logic [31:0] readback;
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (a[2] == ipsa_pkg::REG_ROM_LENGTH)
            rom_len = d[24:0];
        else
            body_len = d;
        n_settings++;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        readback = (a[2] == ipsa_pkg::REG_ROM_LENGTH) ? {7'd0, rom_len} : body_len;
        if (prdata !== readback) begin
            $error("register at %h: expected %h, actual %h", a, readback, prdata);
            failures++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Holds the sender back until every word has been taken and every command
    // has come out, then lets the write stage settle.
    task automatic drain();
        while (bytes_accepted != bytes_queued || rom_cmds_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [7:0]  directed[$];
        logic [24:0] rom;
        logic [31:0] body;
        int          start;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        aresetn   = 1'b0;
        no_gaps   = 1'b0;
        stall_req = 1'b0;
        hold_left = 0;
        rom_len   = '0;
        body_len  = '0;
        restart_parse();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Lower-case header, a data run stepping over the ROM end, and a fill
        // clipped at the ROM end.
        write_reg(ADDR_ROM_LENGTH, 32'h100);
        write_reg(ADDR_BODY_LENGTH, 32'hFFFF_FFFF);
        push_header(MAGIC_LOWER);
        directed = '{8'h00, 8'h00, 8'hFF, 8'h00, 8'h02, 8'h00, 8'hFF,
                     8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h20, 8'hA5};
        foreach (directed[k])
            push_byte(directed[k], 1'b0);
        drain();

        // A correct header with an empty body is rejected.
        write_reg(ADDR_BODY_LENGTH, 32'd0);
        write_reg(ADDR_ROM_LENGTH, 32'h100_0000);
        push_header(MAGIC_UPPER);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin rom = 25'h100_0000; body = 32'hFFFF_FFFF; end
                1: begin rom = 25'h1000;     body = 32'hFFFF_FFFF; end
                2: begin rom = 25'd1;        body = 32'd40; end
                3: begin rom = 25'd0;        body = 32'hFFFF_FFFF; end
                4: begin rom = 25'($urandom_range(1, 32'hFF_FFFF)); body = $urandom_range(8, 80); end
                5: begin rom = 25'h100_0000; body = 32'd1; end
                6: begin rom = 25'h80;       body = $urandom_range(8, 200); end
                default: begin
                    rom  = 25'($urandom_range(1, 32'hFF_FFFF));
                    body = 32'hFFFF_FFFF;
                end
            endcase
            write_reg(ADDR_ROM_LENGTH, {7'd0, rom});
            write_reg(ADDR_BODY_LENGTH, body);
            no_gaps = (ph == 0);
            start = bytes_queued;
            while (bytes_queued - start < PHASE_BYTES)
                send_file(rom);
            // The sink holds off long enough for the command queue to fill
            // and push back on the input.
            if (ph == 1)
                stall_req = 1'b1;
            drain();
        end
        no_gaps = 1'b0;

        $display("Sent %0d patch words across %0d register writes.", bytes_queued, n_settings);
        $display("Checked %0d byte writes, %0d fills and %0d header errors.",
                 n_writes, n_fills, n_errors);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
